[design/spot_pkg.sv]
`default_nettype none

package spot_pkg;

    // default coordinate width, signed Q12.4 at 16 bits
    localparam int SPOT_COORD_BITS = 16;

    // shape pairing of one word, a is the first object and b the second
    typedef enum logic [1:0] {
        KIND_RECT_RECT = 2'd0,
        KIND_CIRC_CIRC = 2'd1,
        KIND_CIRC_RECT = 2'd2,
        KIND_RECT_CIRC = 2'd3
    } t_pair_kind;

endpackage

`default_nettype wire

[design/shape_pair_overlap_test.sv]
`default_nettype none
// Two-shape overlap test: rectangle or circle against rectangle or circle.
// Input channel: drive all i_* fields and raise start; a word is taken at
// every rising edge where start is high and busy is low. busy is always low,
// so one word can be issued every clock cycle.
// Output channel: o_valid is high for exactly one cycle with o_hit, and the
// word is taken at the edge that ends that cycle. The receiver has no way to
// hold results back, and none is needed: results leave in issue order, one
// per issued word.
// Pipeline: four register stages (center differences, bound and slab checks,
// squaring, sum and compare); the result strobe comes from the last of them.
// Throughput: one word per cycle, as no stage stalls; the squaring stage holds
// three COORD_BITS x COORD_BITS multipliers working in parallel.
// Reset (i_rst_n low at a rising edge) clears the valid bits of all stages;
// words in flight are dropped and no strobe follows.
// Coordinates are signed COORD_BITS-bit values, sizes unsigned and one bit
// narrower; rectangle sizes are full width and height, circle size is radius.

module shape_pair_overlap_test
    import spot_pkg::*;
#(
    parameter int COORD_BITS = SPOT_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic [1:0]                   i_pair_kind,
    input  wire logic                         i_a_enabled,
    input  wire logic                         i_b_enabled,
    input  wire logic signed [COORD_BITS-1:0] i_a_center_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_center_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_center_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_center_y,
    input  wire logic [COORD_BITS-2:0]        i_a_size_w,
    input  wire logic [COORD_BITS-2:0]        i_a_size_h,
    input  wire logic [COORD_BITS-2:0]        i_b_size_w,
    input  wire logic [COORD_BITS-2:0]        i_b_size_h,
    output      logic                         o_valid,
    output      logic                         o_hit
);

    localparam int W = COORD_BITS;
    localparam int S = COORD_BITS - 1;

    // stage 1 registers
    logic             r_s1_vld;
    t_pair_kind       r_s1_kind;
    logic             r_s1_en;
    logic [W-1:0]     r_s1_dx;
    logic [W-1:0]     r_s1_dy;
    logic [S-1:0]     r_s1_aw;
    logic [S-1:0]     r_s1_ah;
    logic [S-1:0]     r_s1_bw;
    logic [S-1:0]     r_s1_bh;

    // stage 2 registers
    logic             r_s2_vld;
    logic             r_s2_dec;
    logic             r_s2_dec_hit;
    logic [W-1:0]     r_s2_p;
    logic [W-1:0]     r_s2_q;
    logic [W-1:0]     r_s2_m;

    // stage 3 registers
    logic             r_s3_vld;
    logic             r_s3_dec;
    logic             r_s3_dec_hit;
    logic [2*W-1:0]   r_s3_pp;
    logic [2*W-1:0]   r_s3_qq;
    logic [2*W-1:0]   r_s3_mm;

    // output registers
    logic             r_s4_vld;
    logic             r_s4_hit;

    // stage 1 next values
    logic             n_s1_vld;
    logic signed [W:0] n_s1_dfx;
    logic signed [W:0] n_s1_dfy;
    logic [W:0]       n_s1_adx;
    logic [W:0]       n_s1_ady;

    // stage 2 next values
    logic [W:0]       ddx;
    logic [W:0]       ddy;
    logic [W-1:0]     sum_w;
    logic [W-1:0]     sum_h;
    logic [S-1:0]     rc_w;
    logic [S-1:0]     rc_h;
    logic [S-1:0]     rc_r;
    logic [W-1:0]     rc_r2;
    logic [W:0]       rc_wr;
    logic [W:0]       rc_hr;
    logic [W:0]       rc_ex;
    logic [W:0]       rc_ey;
    logic             rr_hit;
    logic             cc_out;
    logic             rc_out;
    logic             rc_in;
    logic             n_s2_dec;
    logic             n_s2_dec_hit;
    logic [W-1:0]     n_s2_p;
    logic [W-1:0]     n_s2_q;
    logic [W-1:0]     n_s2_m;

    // stage 3 and 4 next values
    logic [2*W-1:0]   n_s3_pp;
    logic [2*W-1:0]   n_s3_qq;
    logic [2*W-1:0]   n_s3_mm;
    logic [2*W:0]     n_s4_sum;
    logic             n_s4_hit;

    // every word is taken as it comes
    assign busy     = 1'b0;
    assign n_s1_vld = start & ~busy;

    // exact absolute center differences
    always_comb begin
        n_s1_dfx = {i_a_center_x[W-1], i_a_center_x} - {i_b_center_x[W-1], i_b_center_x};
        n_s1_dfy = {i_a_center_y[W-1], i_a_center_y} - {i_b_center_y[W-1], i_b_center_y};
        n_s1_adx = n_s1_dfx[W] ? (~n_s1_dfx + {{W{1'b0}}, 1'b1}) : n_s1_dfx;
        n_s1_ady = n_s1_dfy[W] ? (~n_s1_dfy + {{W{1'b0}}, 1'b1}) : n_s1_dfy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind <= t_pair_kind'(i_pair_kind);
        r_s1_en   <= i_a_enabled & i_b_enabled;
        r_s1_dx   <= n_s1_adx[W-1:0];
        r_s1_dy   <= n_s1_ady[W-1:0];
        r_s1_aw   <= i_a_size_w;
        r_s1_ah   <= i_a_size_h;
        r_s1_bw   <= i_b_size_w;
        r_s1_bh   <= i_b_size_h;
    end

    // bound checks on doubled distances
    always_comb begin
        ddx   = {r_s1_dx, 1'b0};
        ddy   = {r_s1_dy, 1'b0};
        sum_w = {1'b0, r_s1_aw} + {1'b0, r_s1_bw};
        sum_h = {1'b0, r_s1_ah} + {1'b0, r_s1_bh};

        // rectangle against rectangle, touching edges hit
        rr_hit = (ddx <= {1'b0, sum_w}) && (ddy <= {1'b0, sum_h});

        // circle against circle, per-axis reject before squaring
        cc_out = (r_s1_dx > sum_w) || (r_s1_dy > sum_w);

        // circle against rectangle: pick rectangle and radius
        if (r_s1_kind == KIND_CIRC_RECT) begin
            rc_w = r_s1_bw;
            rc_h = r_s1_bh;
            rc_r = r_s1_aw;
        end else begin
            rc_w = r_s1_aw;
            rc_h = r_s1_ah;
            rc_r = r_s1_bw;
        end
        rc_r2  = {rc_r, 1'b0};
        rc_wr  = {2'b00, rc_w} + {1'b0, rc_r2};
        rc_hr  = {2'b00, rc_h} + {1'b0, rc_r2};
        rc_out = (ddx > rc_wr) || (ddy > rc_hr);
        rc_in  = (ddx <= {2'b00, rc_w}) || (ddy <= {2'b00, rc_h});
        // corner offsets, at most 2*r once the bound test passed
        rc_ex  = ddx - {2'b00, rc_w};
        rc_ey  = ddy - {2'b00, rc_h};
    end

    // settle the easy cases, else hand operands to the squaring stage
    always_comb begin
        n_s2_dec     = 1'b1;
        n_s2_dec_hit = 1'b0;
        n_s2_p       = r_s1_dx;
        n_s2_q       = r_s1_dy;
        n_s2_m       = sum_w;
        unique case (r_s1_kind)
            KIND_RECT_RECT: begin
                n_s2_dec     = 1'b1;
                n_s2_dec_hit = rr_hit;
            end
            KIND_CIRC_CIRC: begin
                n_s2_dec     = cc_out;
                n_s2_dec_hit = 1'b0;
                n_s2_p       = r_s1_dx;
                n_s2_q       = r_s1_dy;
                n_s2_m       = sum_w;
            end
            KIND_CIRC_RECT, KIND_RECT_CIRC: begin
                n_s2_dec     = rc_out | rc_in;
                n_s2_dec_hit = ~rc_out;
                n_s2_p       = rc_ex[W-1:0];
                n_s2_q       = rc_ey[W-1:0];
                n_s2_m       = rc_r2;
            end
            default: begin
                n_s2_dec     = 1'b1;
                n_s2_dec_hit = 1'b0;
            end
        endcase
        // not collidable forces no hit
        if (!r_s1_en) begin
            n_s2_dec     = 1'b1;
            n_s2_dec_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_dec     <= n_s2_dec;
        r_s2_dec_hit <= n_s2_dec_hit;
        r_s2_p       <= n_s2_p;
        r_s2_q       <= n_s2_q;
        r_s2_m       <= n_s2_m;
    end

    // squares of both offsets and the limit
    always_comb begin
        n_s3_pp = {{W{1'b0}}, r_s2_p} * {{W{1'b0}}, r_s2_p};
        n_s3_qq = {{W{1'b0}}, r_s2_q} * {{W{1'b0}}, r_s2_q};
        n_s3_mm = {{W{1'b0}}, r_s2_m} * {{W{1'b0}}, r_s2_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_dec     <= r_s2_dec;
        r_s3_dec_hit <= r_s2_dec_hit;
        r_s3_pp      <= n_s3_pp;
        r_s3_qq      <= n_s3_qq;
        r_s3_mm      <= n_s3_mm;
    end

    // exact sum of squares against the squared limit
    always_comb begin
        n_s4_sum = {1'b0, r_s3_pp} + {1'b0, r_s3_qq};
        n_s4_hit = r_s3_dec ? r_s3_dec_hit : (n_s4_sum <= {1'b0, r_s3_mm});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_hit <= n_s4_hit;
    end

    assign o_valid = r_s4_vld;
    assign o_hit   = r_s4_hit;

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
    import spot_pkg::*;

    localparam int CW = SPOT_COORD_BITS;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_WORDS = 1030;
    localparam int TAIL_CYCLES = 12;

    // one pair test as issued to the block, plus the idle time after it and a drain flag
    typedef struct {
        t_pair_kind           kind;
        logic                 a_en;
        logic                 b_en;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-2:0]        aw;
        logic [CW-2:0]        ah;
        logic [CW-2:0]        bw;
        logic [CW-2:0]        bh;
        int                   gap;
        bit                   drain;
    } t_shape_word;

    typedef struct {
        bit hit;
        int seq;
    } t_hit_expect;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_pair_kind = '0;
    logic                 i_a_enabled = 1'b0;
    logic                 i_b_enabled = 1'b0;
    logic signed [CW-1:0] i_a_center_x = '0;
    logic signed [CW-1:0] i_a_center_y = '0;
    logic signed [CW-1:0] i_b_center_x = '0;
    logic signed [CW-1:0] i_b_center_y = '0;
    logic [CW-2:0]        i_a_size_w = '0;
    logic [CW-2:0]        i_a_size_h = '0;
    logic [CW-2:0]        i_b_size_w = '0;
    logic [CW-2:0]        i_b_size_h = '0;
    logic                 o_valid;
    logic                 o_hit;

    t_shape_word pending_words[$];
    t_hit_expect expected_hits[$];
    t_shape_word cur_word;
    int          idle_left = 0;
    int          issued_count = 0;
    int          cycle_count = 0;
    int          error_count = 0;
    int          calm_left = 0;

    shape_pair_overlap_test #(
        .COORD_BITS(CW)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pair_kind (i_pair_kind),
        .i_a_enabled (i_a_enabled),
        .i_b_enabled (i_b_enabled),
        .i_a_center_x(i_a_center_x),
        .i_a_center_y(i_a_center_y),
        .i_b_center_x(i_b_center_x),
        .i_b_center_y(i_b_center_y),
        .i_a_size_w  (i_a_size_w),
        .i_a_size_h  (i_a_size_h),
        .i_b_size_w  (i_b_size_w),
        .i_b_size_h  (i_b_size_h),
        .o_valid     (o_valid),
        .o_hit       (o_hit)
    );

    always #5 i_clk = ~i_clk;

    // rectangle of full size w x h against circle of radius r, doubled distances
    function automatic bit rect_circle_hit(longint dx, longint dy, longint w, longint h,
                                           longint r);
        longint ddx;
        longint ddy;
        longint r2;
        ddx = 2 * dx;
        ddy = 2 * dy;
        r2 = 2 * r;
        if (ddx > w + r2 || ddy > h + r2)
            return 1'b0;
        if (ddx <= w || ddy <= h)
            return 1'b1;
        return (ddx - w) * (ddx - w) + (ddy - h) * (ddy - h) <= r2 * r2;
    endfunction

    // expected overlap flag of one word, all arithmetic exact in 64 bits
    function automatic bit overlap_hit(t_shape_word w);
        longint dx;
        longint dy;
        longint aw;
        longint ah;
        longint bw;
        longint bh;
        longint rs;
        dx = longint'(w.ax) - longint'(w.bx);
        dy = longint'(w.ay) - longint'(w.by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        aw = longint'(w.aw);
        ah = longint'(w.ah);
        bw = longint'(w.bw);
        bh = longint'(w.bh);
        if (!(w.a_en && w.b_en))
            return 1'b0;
        case (w.kind)
            KIND_RECT_RECT: begin
                return (2 * dx <= aw + bw) && (2 * dy <= ah + bh);
            end
            KIND_CIRC_CIRC: begin
                rs = aw + bw;
                return dx * dx + dy * dy <= rs * rs;
            end
            KIND_CIRC_RECT: begin
                return rect_circle_hit(dx, dy, bw, bh, aw);
            end
            default: begin
                return rect_circle_hit(dx, dy, aw, ah, bw);
            end
        endcase
    endfunction

    function automatic t_shape_word make_word(t_pair_kind kind, int a_en, int b_en,
                                              int ax, int ay, int bx, int by,
                                              int aw, int ah, int bw, int bh);
        t_shape_word w;
        w.kind = kind;
        w.a_en = (a_en != 0);
        w.b_en = (b_en != 0);
        w.ax = CW'(ax);
        w.ay = CW'(ay);
        w.bx = CW'(bx);
        w.by = CW'(by);
        w.aw = (CW-1)'(aw);
        w.ah = (CW-1)'(ah);
        w.bw = (CW-1)'(bw);
        w.bh = (CW-1)'(bh);
        w.gap = 0;
        w.drain = 1'b0;
        return w;
    endfunction

    function automatic int coord_clamp(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int extreme_size();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 32767;
            2: return 1;
            default: return int'($urandom_range(0, 32767));
        endcase
    endfunction

    // random word: mostly nearby shapes of similar scale so both outcomes occur
    function automatic t_shape_word random_word();
        t_shape_word w;
        int mode;
        int span;
        int ax;
        int ay;
        w = make_word(t_pair_kind'($urandom_range(0, 3)), 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        w.a_en = ($urandom_range(0, 9) != 0);
        w.b_en = ($urandom_range(0, 9) != 0);
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            w.ax = CW'($urandom);
            w.ay = CW'($urandom);
            w.bx = CW'($urandom);
            w.by = CW'($urandom);
            w.aw = (CW-1)'($urandom);
            w.ah = (CW-1)'($urandom);
            w.bw = (CW-1)'($urandom);
            w.bh = (CW-1)'($urandom);
        end else if (mode < 8) begin
            span = 1 << $urandom_range(2, 14);
            ax = int'($urandom_range(0, 65535)) - 32768;
            ay = int'($urandom_range(0, 65535)) - 32768;
            w.ax = CW'(ax);
            w.ay = CW'(ay);
            w.bx = CW'(coord_clamp(ax + int'($urandom_range(0, 2 * span)) - span));
            w.by = CW'(coord_clamp(ay + int'($urandom_range(0, 2 * span)) - span));
            w.aw = (CW-1)'($urandom_range(0, span));
            w.ah = (CW-1)'($urandom_range(0, span));
            w.bw = (CW-1)'($urandom_range(0, span));
            w.bh = (CW-1)'($urandom_range(0, span));
        end else begin
            w.ax = CW'(extreme_coord());
            w.ay = CW'(extreme_coord());
            w.bx = CW'(extreme_coord());
            w.by = CW'(extreme_coord());
            w.aw = (CW-1)'(extreme_size());
            w.ah = (CW-1)'(extreme_size());
            w.bw = (CW-1)'(extreme_size());
            w.bh = (CW-1)'(extreme_size());
        end
        return w;
    endfunction

    // attach idle time and drain points, then queue for the driver
    task automatic queue_word(t_shape_word w);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            w.gap = 0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                calm_left = $urandom_range(20, 80);
                w.gap = 0;
            end else if (r < 45) begin
                w.gap = 0;
            end else if (r < 90) begin
                w.gap = $urandom_range(1, 3);
            end else begin
                w.gap = $urandom_range(8, 40);
            end
        end
        w.drain = (pending_words.size() % 250 == 20);
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // driver: records each accepted word, then holds, idles or issues the next
    always @(posedge i_clk) begin
        t_shape_word nxt;
        bit taken;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && busy === 1'b0;
            if (taken) begin
                expected_hits.push_back('{hit: overlap_hit(cur_word), seq: issued_count});
                issued_count++;
            end
            if (start && !taken) begin
                // hold the word until the block takes it
            end else if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         (!pending_words[0].drain ||
                          (!taken && expected_hits.size() == 0))) begin
                nxt = pending_words.pop_front();
                cur_word <= nxt;
                i_pair_kind <= nxt.kind;
                i_a_enabled <= nxt.a_en;
                i_b_enabled <= nxt.b_en;
                i_a_center_x <= nxt.ax;
                i_a_center_y <= nxt.ay;
                i_b_center_x <= nxt.bx;
                i_b_center_y <= nxt.by;
                i_a_size_w <= nxt.aw;
                i_a_size_h <= nxt.ah;
                i_b_size_w <= nxt.bw;
                i_b_size_h <= nxt.bh;
                idle_left <= nxt.gap;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: each strobed word checked against the oldest expectation
    always @(posedge i_clk) begin
        t_hit_expect want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (o_valid !== 1'b1) begin
                report_mismatch("result strobe unknown");
            end else if (expected_hits.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = expected_hits.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("word %0d: hit %b, expected %b",
                                              want.seq, o_hit, want.hit));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        // touching and separated rectangles, enables
        queue_word(make_word(KIND_RECT_RECT, 1, 1, 0, 0, 10, 0, 10, 10, 10, 10));
        queue_word(make_word(KIND_RECT_RECT, 1, 1, 0, 0, 11, 0, 10, 10, 10, 10));
        queue_word(make_word(KIND_RECT_RECT, 1, 1, -32768, 0, 32767, 0,
                             32767, 32767, 32767, 32767));
        queue_word(make_word(KIND_RECT_RECT, 1, 1, 5, 0, 5, 32767,
                             32767, 32767, 32767, 32767));
        queue_word(make_word(KIND_RECT_RECT, 0, 1, 0, 0, 10, 0, 10, 10, 10, 10));
        queue_word(make_word(KIND_RECT_RECT, 1, 0, 0, 0, 10, 0, 10, 10, 10, 10));
        queue_word(make_word(KIND_RECT_RECT, 1, 1, 0, 0, 0, 50, 0, 100, 0, 0));
        // circles: touching, just apart, widest spans, points
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, 0, 0, 3, 4, 2, 0, 3, 0));
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, 0, 0, 3, 4, 2, 0, 2, 0));
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, -32768, -32768, 32767, 32767,
                             32767, 32767, 32767, 32767));
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, -32767, 0, 32767, 0,
                             32767, 0, 32767, 0));
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, -32768, 32767, -32768, -32768,
                             32767, 0, 32767, 0));
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, 7, -7, 7, -7, 0, 0, 0, 0));
        queue_word(make_word(KIND_CIRC_CIRC, 1, 1, 7, -7, 8, -7, 0, 0, 0, 0));
        // circle against rectangle: corner region, slab edge, point rectangle
        queue_word(make_word(KIND_CIRC_RECT, 1, 1, 13, 13, 0, 0, 5, 0, 20, 20));
        queue_word(make_word(KIND_CIRC_RECT, 1, 1, 13, 13, 0, 0, 4, 0, 20, 20));
        queue_word(make_word(KIND_RECT_CIRC, 1, 1, 0, 0, 20, 0, 20, 20, 10, 0));
        queue_word(make_word(KIND_RECT_CIRC, 1, 1, 0, 0, 21, 0, 20, 20, 10, 0));
        queue_word(make_word(KIND_RECT_CIRC, 1, 1, 0, 0, 3, 4, 0, 0, 5, 0));
        queue_word(make_word(KIND_RECT_CIRC, 1, 1, 0, 0, 3, 4, 0, 0, 4, 32767));
        queue_word(make_word(KIND_RECT_CIRC, 1, 1, -32768, -32768, 32767, 32767,
                             32767, 32767, 32767, 32767));
        queue_word(make_word(KIND_RECT_CIRC, 1, 1, -32768, 32767, 0, 0,
                             32767, 32767, 32767, 32767));
        queue_word(make_word(KIND_CIRC_RECT, 0, 0, 0, 0, 0, 0, 5, 5, 5, 5));
        // random words
        for (int n = 0; n < RANDOM_WORDS; n++)
            queue_word(random_word());

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || start)
            @(posedge i_clk);
        while (expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
